// File: src/ham6pcd_pkg.sv
// ----------------------------------------------------------------------------
// ham6pcd_pkg
// shared constants and types of the ham6 pixel colour decoder
// ----------------------------------------------------------------------------
package ham6pcd_pkg;

    localparam int PALETTE_DEPTH = 16;
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
    localparam int COLOUR_W      = 24;
    localparam int PIXEL_W       = 24;
    localparam int MAP_W         = 9;
    localparam int CFG_DATA_W    = 9;

    // item modes
    localparam logic [1:0] MODE_PIXEL = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;

    // pixel formats
    localparam logic [1:0] FMT_INDEXED = 2'd0;
    localparam logic [1:0] FMT_HAM     = 2'd1;
    localparam logic [1:0] FMT_DIRECT  = 2'd2;

    // ham control codes
    localparam logic [1:0] HAM_PALETTE = 2'd0;
    localparam logic [1:0] HAM_BLUE    = 2'd1;
    localparam logic [1:0] HAM_RED     = 2'd2;

    // configuration register indexes
    localparam logic REG_PIXEL_FORMAT = 1'b0;
    localparam logic REG_MAP_SIZE     = 1'b1;

    localparam logic [MAP_W-1:0] MAP_LIMIT = 9'd256;

    typedef struct packed {
        logic                 fire;
        logic [1:0]           mode;
        logic [PIXEL_W-1:0]   pixel_value;
    } ham6pcd_stage_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] colour_index;
        logic       range_error;
    } ham6pcd_result_t;

endpackage

// File: src/ham6pcd_if.sv
// ----------------------------------------------------------------------------
// ham6pcd_if
// valid/ready channels for pixel items and colour results
// ----------------------------------------------------------------------------
interface ham6pcd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [23:0] pixel_value;
    logic [3:0]  entry_index;
    logic [7:0]  entry_red;
    logic [7:0]  entry_green;
    logic [7:0]  entry_blue;

    modport source (output valid, mode, pixel_value, entry_index, entry_red, entry_green,
                    entry_blue, input ready);
    modport sink   (input valid, mode, pixel_value, entry_index, entry_red, entry_green,
                    entry_blue, output ready);
endinterface

interface ham6pcd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] colour_index;
    logic       range_error;

    modport source (output valid, red, green, blue, colour_index, range_error, input ready);
    modport sink   (input valid, red, green, blue, colour_index, range_error, output ready);
endinterface

// File: src/ham6pcd_ram.sv
// ----------------------------------------------------------------------------
// ham6pcd_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module ham6pcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/ham6pcd_colour.sv
// ----------------------------------------------------------------------------
// ham6pcd_colour
// held colour registers and colour forming for the second stage
// ----------------------------------------------------------------------------
module ham6pcd_colour
    import ham6pcd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ham6pcd_stage_t        stage,
    input  logic [COLOUR_W-1:0]   entry,
    input  logic [1:0]            pixel_format,
    input  logic [MAP_W-1:0]      map_size,
    output ham6pcd_result_t       result
);

    logic [7:0] held_red_reg,   held_red_next;
    logic [7:0] held_green_reg, held_green_next;
    logic [7:0] held_blue_reg,  held_blue_next;
    logic [7:0] nibble2;
    logic [MAP_W-1:0] limit;
    logic [PIXEL_W-1:0] pv;

    assign pv      = stage.pixel_value;
    assign nibble2 = {pv[3:0], pv[3:0]};
    assign limit   = (map_size > MAP_LIMIT) ? MAP_LIMIT : map_size;

    always_comb
    begin
        held_red_next   = held_red_reg;
        held_green_next = held_green_reg;
        held_blue_next  = held_blue_reg;
        result          = '0;
        case (stage.mode)
            MODE_START:
            begin
                held_red_next   = entry[23:16];
                held_green_next = entry[15:8];
                held_blue_next  = entry[7:0];
            end
            MODE_PIXEL:
            begin
                case (pixel_format)
                    FMT_INDEXED:
                    begin
                        result.colour_index = pv[7:0];
                        result.range_error  = (pv[PIXEL_W-1:MAP_W] != '0) ||
                                              (pv[MAP_W-1:0] >= limit);
                    end
                    FMT_HAM:
                    begin
                        case (pv[5:4])
                            HAM_PALETTE:
                            begin
                                held_red_next   = entry[23:16];
                                held_green_next = entry[15:8];
                                held_blue_next  = entry[7:0];
                            end
                            HAM_BLUE: held_blue_next  = nibble2;
                            HAM_RED:  held_red_next   = nibble2;
                            default:  held_green_next = nibble2;
                        endcase
                        result.red   = held_red_next;
                        result.green = held_green_next;
                        result.blue  = held_blue_next;
                    end
                    FMT_DIRECT:
                    begin
                        result.red   = pv[23:16];
                        result.green = pv[15:8];
                        result.blue  = pv[7:0];
                    end
                    default:
                    begin
                        result = '0;
                    end
                endcase
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_red_reg   <= '0;
            held_green_reg <= '0;
            held_blue_reg  <= '0;
        end
        else if (stage.fire)
        begin
            held_red_reg   <= held_red_next;
            held_green_reg <= held_green_next;
            held_blue_reg  <= held_blue_next;
        end
    end

endmodule

// File: src/ham6_pixel_colour_decoder_unit.sv
// ----------------------------------------------------------------------------
// ham6_pixel_colour_decoder_unit
// turns pixel values into indexed, ham6 or direct 24-bit colours
// ----------------------------------------------------------------------------
// The unit takes one item per clock and gives one result per pixel item. In the
// cycle of the transfer a palette write goes into the 16-entry palette ram, and
// any other item issues its palette read (entry 0 for an image start, the low
// nibble of the pixel for a pixel). In the second stage the registered palette
// word and the held colour registers form the colour, the held colour is
// updated, and the result is loaded into the output register. The held colour
// loop closes within that one stage, and a palette write is in the ram before
// the read of the following item, so back-to-back items need no interlock. The
// rate is bounded only by the output side: while the output register is full
// and not taken, a pixel item waits in the second stage and the input stalls
// behind it. Palette writes, image starts and items of mode three give no
// result. Palette entries hold nothing useful until written; there is no
// clearing pass after reset. The user must write configuration (cfg_we,
// cfg_index, cfg_wdata) only while the unit is idle; the unit does not check.
// ----------------------------------------------------------------------------
module ham6_pixel_colour_decoder_unit
    import ham6pcd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    ham6pcd_in_if.sink            pixel_in,
    ham6pcd_out_if.source         colour_out
);

    // configuration registers
    logic [1:0]       pixel_format_reg;
    logic [MAP_W-1:0] map_size_reg;

    // second stage: item waiting on its palette word
    logic               s1_valid_reg;
    logic [1:0]         s1_mode_reg;
    logic [PIXEL_W-1:0] s1_pv_reg;

    // output register
    logic            out_valid_reg;
    ham6pcd_result_t out_reg;

    logic                in_xfer;
    logic                s1_adv;
    logic                s1_pixel;
    logic [PAL_AW-1:0]   rd_addr;
    logic [COLOUR_W-1:0] rd_entry;
    ham6pcd_stage_t      stage;
    ham6pcd_result_t     result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_format_reg <= FMT_INDEXED;
            map_size_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PIXEL_FORMAT: pixel_format_reg <= cfg_wdata[1:0];
                REG_MAP_SIZE:     map_size_reg     <= cfg_wdata[MAP_W-1:0];
                default:          map_size_reg     <= map_size_reg;
            endcase
        end
    end

    // a pixel item leaves the second stage only when the output register is free
    assign s1_pixel = (s1_mode_reg == MODE_PIXEL);
    assign s1_adv   = s1_valid_reg && (!s1_pixel || !out_valid_reg || colour_out.ready);
    assign pixel_in.ready = !s1_valid_reg || s1_adv;
    assign in_xfer  = pixel_in.valid && pixel_in.ready;

    // image start reads entry 0, a pixel reads its low nibble
    assign rd_addr = (pixel_in.mode == MODE_START) ? '0 : pixel_in.pixel_value[PAL_AW-1:0];

    ham6pcd_ram #(
        .WIDTH (COLOUR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (in_xfer && (pixel_in.mode == MODE_WRITE)),
        .waddr (pixel_in.entry_index),
        .wdata ({pixel_in.entry_red, pixel_in.entry_green, pixel_in.entry_blue}),
        .re    (in_xfer),
        .raddr (rd_addr),
        .rdata (rd_entry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // stage payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_mode_reg <= pixel_in.mode;
            s1_pv_reg   <= pixel_in.pixel_value;
        end
    end

    assign stage.fire        = s1_adv;
    assign stage.mode        = s1_mode_reg;
    assign stage.pixel_value = s1_pv_reg;

    ham6pcd_colour u_colour (
        .clk          (clk),
        .rst_n        (rst_n),
        .stage        (stage),
        .entry        (rd_entry),
        .pixel_format (pixel_format_reg),
        .map_size     (map_size_reg),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && s1_pixel)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (colour_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_pixel)
        begin
            out_reg <= result;
        end
    end

    assign colour_out.valid        = out_valid_reg;
    assign colour_out.red          = out_reg.red;
    assign colour_out.green        = out_reg.green;
    assign colour_out.blue         = out_reg.blue;
    assign colour_out.colour_index = out_reg.colour_index;
    assign colour_out.range_error  = out_reg.range_error;

    // input only stalls behind an occupied second stage
    a_ready_stall : assert property (@(posedge clk) disable iff (!rst_n)
        !pixel_in.ready |-> s1_valid_reg)
        else $error("input stalled with empty second stage");

    // an item that gives no result never fills an empty output register
    a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_pixel && !out_valid_reg |=> !out_valid_reg)
        else $error("result produced by a non-pixel item");

    // a pixel item held behind a stalled output stays in the second stage
    a_pixel_hold : assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_pixel && out_valid_reg && !colour_out.ready |=> s1_valid_reg)
        else $error("pixel item lost while output stalled");

    // indexed results carry no colour
    a_indexed_zero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.colour_index != '0 || out_reg.range_error) |->
        (out_reg.red == '0 && out_reg.green == '0 && out_reg.blue == '0))
        else $error("indexed result with non-zero colour");

endmodule

// File: tb/tb_ham6_pixel_colour_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_ham6_pixel_colour_decoder_unit
// self-checking testbench for the ham6 pixel colour decoder unit
// ----------------------------------------------------------------------------
// A stimulus process builds the item list phase by phase: directed corner
// cases first, then random traffic in every pixel format, with the
// configuration written only while the unit is idle. A driver offers the
// items on the pixel channel. A monitor works out the colour of every accepted
// pixel from its own copy of the palette and held colour, and compares each
// colour transfer with the oldest outstanding colour. Sender gaps and
// receiver stalls change from phase to phase, with one long output hold-off.
// ----------------------------------------------------------------------------
module tb_ham6_pixel_colour_decoder_unit;
    import ham6pcd_pkg::*;

    // codes with no name in the package
    localparam logic [1:0] MODE_IGNORED = 2'd3;
    localparam logic [1:0] FMT_UNUSED   = 2'd3;
    localparam logic [1:0] HAM_GREEN    = 2'd3;

    localparam int SETTLE_CYCLES  = 4;     // two-stage pipe plus margin
    localparam int HOLD_CYCLES    = 60;    // long output hold-off
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer

    typedef struct packed {
        logic [1:0]         mode;
        logic [PIXEL_W-1:0] pixel_value;
        logic [PAL_AW-1:0]  entry_index;
        logic [7:0]         entry_red;
        logic [7:0]         entry_green;
        logic [7:0]         entry_blue;
    } pixel_item_t;

    // ------------------------------------------------------------------------
    // clock, reset and the signals driven into the unit
    // ------------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic                  cfg_index = REG_PIXEL_FORMAT;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid  = 1'b0;
    pixel_item_t           in_item   = '0;
    logic                  out_ready = 1'b0;

    ham6pcd_in_if  pix_if ();
    ham6pcd_out_if col_if ();

    // channel inputs follow the testbench registers, so they are known from time zero
    assign pix_if.valid       = in_valid;
    assign pix_if.mode        = in_item.mode;
    assign pix_if.pixel_value = in_item.pixel_value;
    assign pix_if.entry_index = in_item.entry_index;
    assign pix_if.entry_red   = in_item.entry_red;
    assign pix_if.entry_green = in_item.entry_green;
    assign pix_if.entry_blue  = in_item.entry_blue;
    assign col_if.ready       = out_ready;

    ham6_pixel_colour_decoder_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .pixel_in   (pix_if),
        .colour_out (col_if)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // shared state
    // ------------------------------------------------------------------------
    pixel_item_t     stimulus_items [$];    // filled by the stimulus process
    int              send_idx = 0;          // next item the driver offers
    ham6pcd_result_t expected_colours [$];  // colours still to come back

    // own copy of the unit's state and configuration
    logic [COLOUR_W-1:0] palette_copy [PALETTE_DEPTH];
    logic [7:0]          hold_r = '0;
    logic [7:0]          hold_g = '0;
    logic [7:0]          hold_b = '0;
    logic [1:0]          cur_format   = FMT_INDEXED;
    logic [MAP_W-1:0]    cur_map_size = '0;

    // entries written so far, so that no pixel or start ever reads an unwritten entry
    bit palette_loaded [PALETTE_DEPTH];

    // idling controls, set per phase
    int send_gap_pct  = 0;
    int stall_pct     = 0;
    int hold_requests = 0;

    // run statistics
    int mismatches      = 0;
    int colours_checked = 0;
    int range_flags     = 0;
    int pixels_in       = 0;
    int writes_in       = 0;
    int starts_in       = 0;
    int ignored_in      = 0;

    // ------------------------------------------------------------------------
    // colour prediction: updates the state copy, returns 1 when a colour is due
    // ------------------------------------------------------------------------
    function automatic bit predict_colour(input pixel_item_t px, output ham6pcd_result_t colour);
        logic [3:0]       nib;
        logic [MAP_W-1:0] limit;
        colour = '0;
        nib    = px.pixel_value[3:0];
        if (px.mode == MODE_WRITE)
        begin
            palette_copy[px.entry_index] = {px.entry_red, px.entry_green, px.entry_blue};
            return 1'b0;
        end
        if (px.mode == MODE_START)
        begin
            {hold_r, hold_g, hold_b} = palette_copy[0];
            return 1'b0;
        end
        if (px.mode != MODE_PIXEL)
            return 1'b0;

        case (cur_format)
            FMT_INDEXED:
            begin
                // map sizes above 256 behave as 256
                limit = (cur_map_size > MAP_LIMIT) ? MAP_LIMIT : cur_map_size;
                colour.colour_index = px.pixel_value[7:0];
                colour.range_error  = (px.pixel_value >= limit);
            end
            FMT_HAM:
            begin
                // only bits 5:0 matter, the rest of the value is ignored
                case (px.pixel_value[5:4])
                    HAM_PALETTE: {hold_r, hold_g, hold_b} = palette_copy[nib];
                    HAM_BLUE:    hold_b = {nib, nib};
                    HAM_RED:     hold_r = {nib, nib};
                    HAM_GREEN:   hold_g = {nib, nib};
                endcase
                colour.red   = hold_r;
                colour.green = hold_g;
                colour.blue  = hold_b;
            end
            FMT_DIRECT:
                {colour.red, colour.green, colour.blue} = px.pixel_value;
            default: ;  // unused format: all fields zero, held colour untouched
        endcase
        return 1'b1;
    endfunction

    task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic write_register(input logic idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_PIXEL_FORMAT)
            cur_format = data[1:0];
        else
            cur_map_size = data[MAP_W-1:0];
    endtask

    task automatic queue_item(input logic [1:0] mode, input logic [PIXEL_W-1:0] value,
                              input logic [PAL_AW-1:0] idx, input logic [23:0] rgb);
        pixel_item_t       it;
        logic [PAL_AW-1:0] read_entry;
        // the unit reads the palette for every pixel and start, whatever the
        // format, so make sure the entry it reads holds something
        read_entry = (mode == MODE_START) ? '0 : value[PAL_AW-1:0];
        if ((mode == MODE_PIXEL || mode == MODE_START) && !palette_loaded[read_entry])
            queue_item(MODE_WRITE, PIXEL_W'($urandom), read_entry, 24'($urandom));
        if (mode == MODE_WRITE)
            palette_loaded[idx] = 1'b1;
        it.mode        = mode;
        it.pixel_value = value;
        it.entry_index = idx;
        it.entry_red   = rgb[23:16];
        it.entry_green = rgb[15:8];
        it.entry_blue  = rgb[7:0];
        stimulus_items.push_back(it);
    endtask

    task automatic queue_random_item(input logic [1:0] fmt, output bit counted);
        int unsigned        pick;
        logic [PIXEL_W-1:0] value;
        pick    = $urandom_range(99);
        value   = PIXEL_W'($urandom);
        counted = 1'b1;
        // indexed values mostly close to the map size, so both sides of the check are hit
        if (fmt == FMT_INDEXED && $urandom_range(3) != 0)
            value = PIXEL_W'($urandom_range(511));
        if (pick < 10)
            queue_item(MODE_WRITE, value, PAL_AW'($urandom), 24'($urandom));
        else if (pick < 15)
            queue_item(MODE_START, value, PAL_AW'($urandom), 24'($urandom));
        else if (pick < 18)
        begin
            queue_item(MODE_IGNORED, value, PAL_AW'($urandom), 24'($urandom));
            counted = 1'b0;
        end
        else
            queue_item(MODE_PIXEL, value, PAL_AW'($urandom), 24'($urandom));
    endtask

    // sender pauses here until every colour is back and the pipe is quiet
    task automatic wait_until_drained();
        while (send_idx != stimulus_items.size() || in_valid || expected_colours.size() != 0)
            @(posedge clk);
        // a trailing palette write or start may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic begin_phase(input logic [1:0] fmt, input logic [MAP_W-1:0] map,
                               input int gap, input int stall);
        wait_until_drained();
        write_register(REG_PIXEL_FORMAT, CFG_DATA_W'(fmt));
        write_register(REG_MAP_SIZE, CFG_DATA_W'(map));
        send_gap_pct = gap;
        stall_pct    = stall;
    endtask

    task automatic random_phase(input logic [1:0] fmt, input logic [MAP_W-1:0] map,
                                input int gap, input int stall, input int count,
                                input bit long_hold);
        int queued;
        bit counted;
        begin_phase(fmt, map, gap, stall);
        if (long_hold)
            hold_requests++;
        queued = 0;
        while (queued < count)
        begin
            queue_random_item(fmt, counted);
            queued += counted;
            // halfway through, stop sending until everything has come back
            if (counted && queued == count / 2)
                wait_until_drained();
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: offers queued items, holds each until its transfer
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || pix_if.ready)
        begin
            if (send_idx < stimulus_items.size() && $urandom_range(99) >= send_gap_pct)
            begin
                in_item  <= stimulus_items[send_idx];
                in_valid <= 1'b1;
                send_idx <= send_idx + 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // colour receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------------
    int hold_served = 0;
    int hold_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
            out_ready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left  = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // ------------------------------------------------------------------------
    // monitor: checks colour transfers, predicts from item transfers
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : colour_monitor
        ham6pcd_result_t want;
        if (rst_n)
        begin
            if (col_if.valid && col_if.ready)
            begin
                colours_checked++;
                if (col_if.range_error === 1'b1)
                    range_flags++;
                if (expected_colours.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: colour transfer with none outstanding: %0h %0h %0h %0h %0b",
                             $time, col_if.red, col_if.green, col_if.blue,
                             col_if.colour_index, col_if.range_error);
                end
                else
                begin
                    want = expected_colours.pop_front();
                    check_field("red", want.red, col_if.red);
                    check_field("green", want.green, col_if.green);
                    check_field("blue", want.blue, col_if.blue);
                    check_field("colour_index", want.colour_index, col_if.colour_index);
                    check_field("range_error", 8'(want.range_error), 8'(col_if.range_error));
                end
            end
            if (pix_if.valid && pix_if.ready)
            begin
                case (in_item.mode)
                    MODE_PIXEL: pixels_in++;
                    MODE_WRITE: writes_in++;
                    MODE_START: starts_in++;
                    default:    ignored_in++;
                endcase
                if (predict_colour(in_item, want))
                    expected_colours.push_back(want);
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: ends the run when nothing moves for too long
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (pix_if.valid && pix_if.ready) || (col_if.valid && col_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // ham6: start from entry 0, every control code, nibble extremes,
        // upper value bits set, an ignored item in the middle
        begin_phase(FMT_HAM, 9'd0, 0, 0);
        queue_item(MODE_WRITE, PIXEL_W'($urandom), 4'd0, 24'hFF00FF);
        queue_item(MODE_WRITE, PIXEL_W'($urandom), 4'd15, 24'h00FF00);
        queue_item(MODE_START, PIXEL_W'($urandom), PAL_AW'($urandom), 24'($urandom));
        queue_item(MODE_PIXEL, 24'h00001F, PAL_AW'($urandom), 24'($urandom));
        queue_item(MODE_PIXEL, 24'h000020, PAL_AW'($urandom), 24'($urandom));
        queue_item(MODE_PIXEL, 24'hFFFFF5, PAL_AW'($urandom), 24'($urandom));
        queue_item(MODE_PIXEL, 24'h00000F, PAL_AW'($urandom), 24'($urandom));
        queue_item(MODE_PIXEL, 24'hFFFFC0, PAL_AW'($urandom), 24'($urandom));
        queue_item(MODE_IGNORED, PIXEL_W'($urandom), PAL_AW'($urandom), 24'($urandom));
        queue_item(MODE_PIXEL, 24'h00003A, PAL_AW'($urandom), 24'($urandom));

        // indexed at the full map: edge of the range and the widest value
        begin_phase(FMT_INDEXED, MAP_LIMIT, 0, 0);
        queue_item(MODE_PIXEL, 24'h0000FF, PAL_AW'($urandom), 24'($urandom));
        queue_item(MODE_PIXEL, 24'h000100, PAL_AW'($urandom), 24'($urandom));
        queue_item(MODE_PIXEL, 24'hFFFFFF, PAL_AW'($urandom), 24'($urandom));

        // empty map flags everything
        begin_phase(FMT_INDEXED, 9'd0, 0, 0);
        queue_item(MODE_PIXEL, 24'h000000, PAL_AW'($urandom), 24'($urandom));

        // map size above 256 acts as 256
        begin_phase(FMT_INDEXED, 9'h1FF, 0, 0);
        queue_item(MODE_PIXEL, 24'h0000FF, PAL_AW'($urandom), 24'($urandom));
        queue_item(MODE_PIXEL, 24'h000100, PAL_AW'($urandom), 24'($urandom));

        // direct colour leaves the held colour alone, checked by the ham pixel after
        begin_phase(FMT_DIRECT, 9'd1, 0, 0);
        queue_item(MODE_PIXEL, 24'hFFFFFF, PAL_AW'($urandom), 24'($urandom));
        queue_item(MODE_PIXEL, 24'h000000, PAL_AW'($urandom), 24'($urandom));
        queue_item(MODE_PIXEL, 24'hA5C30F, PAL_AW'($urandom), 24'($urandom));
        begin_phase(FMT_HAM, 9'd1, 0, 0);
        queue_item(MODE_PIXEL, 24'h000015, PAL_AW'($urandom), 24'($urandom));

        // unused format gives an all-zero colour; a start still loads the held colour
        begin_phase(FMT_UNUSED, 9'd1, 0, 0);
        queue_item(MODE_PIXEL, 24'hFFFFFF, PAL_AW'($urandom), 24'($urandom));
        queue_item(MODE_START, PIXEL_W'($urandom), PAL_AW'($urandom), 24'($urandom));
        queue_item(MODE_IGNORED, PIXEL_W'($urandom), PAL_AW'($urandom), 24'($urandom));

        // random traffic; the third phase holds the output off while the
        // sender keeps going, so the unit fills and stalls its input
        random_phase(FMT_HAM, MAP_W'($urandom), 0, 0, 90, 1'b0);
        random_phase(FMT_INDEXED, MAP_LIMIT, 45, 0, 60, 1'b0);
        random_phase(FMT_HAM, MAP_W'($urandom), 0, 45, 70, 1'b1);
        random_phase(FMT_DIRECT, MAP_W'($urandom), 19, 19, 50, 1'b0);
        random_phase(FMT_INDEXED, MAP_W'($urandom), 0, 45, 50, 1'b0);
        random_phase(FMT_HAM, MAP_W'($urandom), 19, 19, 100, 1'b0);
        random_phase(FMT_UNUSED, MAP_W'($urandom), 45, 0, 20, 1'b0);
        random_phase(FMT_INDEXED, MAP_W'($urandom_range(1, 255)), 19, 19, 20, 1'b0);

        wait_until_drained();
        repeat (8) @(posedge clk);

        $display("run covered %0d pixels in all four formats, %0d palette writes,",
                 pixels_in, writes_in);
        $display("%0d starts, %0d ignored items, %0d colours checked (%0d range flags)",
                 starts_in, ignored_in, colours_checked, range_flags);
        $display("%0d mismatches, %0d colours missing", mismatches, expected_colours.size());
        if (mismatches == 0 && expected_colours.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
